### sv/irs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irs_pkg;

  localparam int SYMBOL_CODES = 16;
  localparam int SYM_W        = $clog2(SYMBOL_CODES);
  localparam int POS_W        = 32;
  localparam int CNT_W        = 8;
  localparam int MINLEN_W     = 32;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int RQ_DEPTH     = 4;
  localparam int RQ_PTR_W     = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W     = $clog2(RQ_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VALID_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTR_BUDGET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORTEST_LEN = 2'd3;

  typedef struct packed {
    logic [SYMBOL_CODES-1:0] valid_mask;
    logic [SYMBOL_CODES-1:0] invalid_mask;
    logic [CNT_W-1:0]        intr_budget;
    logic [MINLEN_W-1:0]     shortest_len;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] segment_begin;
    logic [POS_W-1:0] segment_end;
    logic             end_of_burst;
  } res_t;

  // Up to two results caused by one item, in delivery order
  typedef struct packed {
    logic v0;
    res_t r0;
    logic v1;
    res_t r1;
  } burst_t;

endpackage

`default_nettype wire

### sv/irs_core.sv
`timescale 1ns / 1ps
`default_nettype none

module irs_core import irs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_go,
  input  logic [SYM_W-1:0] symbol,
  input  logic             last_symbol,
  input  cfg_t             cfg,
  output burst_t           burst
);

  logic             inside_run, inside_run_next;
  logic [CNT_W-1:0] interrupt_count, interrupt_count_next;
  logic [POS_W-1:0] run_begin, run_begin_next;
  logic [POS_W-1:0] position, position_next;
  // run_len tracks position - run_begin
  logic [POS_W-1:0] run_len, run_len_next;

  logic             is_valid, is_invalid, fail;
  logic [CNT_W-1:0] cnt_keep;
  logic [POS_W-1:0] max_ext, back, len0, end0, pos_inc, len1, begin1;

  always_comb begin
    is_valid   = cfg.valid_mask[symbol];
    is_invalid = cfg.invalid_mask[symbol];
    fail       = 1'b0;
    cnt_keep   = '0;
    if (!inside_run) begin
      fail = !is_valid;
    end else if (is_invalid && (interrupt_count < cfg.intr_budget)) begin
      cnt_keep = interrupt_count + CNT_W'(1);
    end else if (!is_valid) begin
      fail = 1'b1;
    end

    // back off the end by up to the interruption budget
    max_ext = POS_W'(cfg.intr_budget);
    back    = (max_ext < run_len) ? max_ext : run_len;
    len0    = run_len - back;
    end0    = position - back;
    pos_inc = position + POS_W'(1);
    len1    = fail ? '0 : run_len + POS_W'(1);
    begin1  = fail ? pos_inc : run_begin;

    burst.v0               = item_go && fail && (MINLEN_W'(len0) >= cfg.shortest_len);
    burst.r0.segment_begin = run_begin;
    burst.r0.segment_end   = end0;
    burst.v1               = item_go && last_symbol && (MINLEN_W'(len1) >= cfg.shortest_len);
    burst.r1.segment_begin = begin1;
    burst.r1.segment_end   = pos_inc;
    burst.r0.end_of_burst  = !burst.v1;
    burst.r1.end_of_burst  = 1'b1;
  end

  always_comb begin
    inside_run_next      = inside_run;
    interrupt_count_next = interrupt_count;
    run_begin_next       = run_begin;
    position_next        = position;
    run_len_next         = run_len;
    if (item_go) begin
      if (last_symbol) begin
        inside_run_next      = 1'b0;
        interrupt_count_next = '0;
        run_begin_next       = '0;
        position_next        = '0;
        run_len_next         = '0;
      end else begin
        inside_run_next      = !fail;
        interrupt_count_next = fail ? '0 : cnt_keep;
        run_begin_next       = begin1;
        position_next        = pos_inc;
        run_len_next         = len1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_run      <= 1'b0;
      interrupt_count <= '0;
      run_begin       <= '0;
      position        <= '0;
      run_len         <= '0;
    end else begin
      inside_run      <= inside_run_next;
      interrupt_count <= interrupt_count_next;
      run_begin       <= run_begin_next;
      position        <= position_next;
      run_len         <= run_len_next;
    end
  end

endmodule

`default_nettype wire

### sv/irs_rq.sv
`timescale 1ns / 1ps
`default_nettype none

module irs_rq import irs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  burst_t              burst,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output res_t                out_res
);

  res_t                entry [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [RQ_PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [RQ_CNT_W-1:0] count, count_next;
  logic [RQ_PTR_W-1:0] wr_ptr_inc;
  logic [1:0]          n_push;
  logic                pop;
  res_t                first;

  always_comb begin
    n_push      = {1'b0, burst.v0} + {1'b0, burst.v1};
    first       = burst.v0 ? burst.r0 : burst.r1;
    pop         = out_valid && out_ready;
    wr_ptr_inc  = wr_ptr + RQ_PTR_W'(1);
    wr_ptr_next = wr_ptr + RQ_PTR_W'(n_push);
    rd_ptr_next = pop ? rd_ptr + RQ_PTR_W'(1) : rd_ptr;
    count_next  = count + RQ_CNT_W'(n_push) - RQ_CNT_W'(pop);
    room        = count <= RQ_CNT_W'(RQ_DEPTH - 2);
    out_valid   = count != '0;
    out_res     = entry[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entry[wr_ptr] <= first;
    end
    if (n_push == 2'd2) begin
      entry[wr_ptr_inc] <= burst.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

### sv/interrupted_run_segmenter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata (low bit up)                  tlast        tuser
// s_axis    in         symbol[3:0], zero pad to 8 bits     last_symbol  -
// m_axis    out        segment_begin[31:0], segment_end    end_of_burst -
// cfg       in         write enable, index, 32-bit data    -            -
//
// An item waits in the input register until the queue has room, then the segment logic
// pushes its zero, one or two results into a four-entry result queue.
// One item per cycle sustained while each causes at most one result and m_axis is
// not stalled; items that cause two are limited by the one-per-cycle result port.
// Input stalls only while the queue holds more than two results.
// Reset is synchronous; it clears the run state, queue, configuration registers and input valid flag.

module interrupted_run_segmenter import irs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // symbol[3:0], pad
  input  logic                 s_axis_tlast,   // last_symbol
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*POS_W-1:0]   m_axis_tdata,   // segment_begin, segment_end
  output logic                 m_axis_tlast,   // end_of_burst
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t             cfg;
  logic             in_valid;
  logic [SYM_W-1:0] sym_q;
  logic             last_q;
  logic             room;
  logic             advance;
  burst_t           burst;
  res_t             out_res;

  // Configuration registers: plain write, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VALID_MASK:   cfg.valid_mask   <= cfg_data[SYMBOL_CODES-1:0];
        REG_INVALID_MASK: cfg.invalid_mask <= cfg_data[SYMBOL_CODES-1:0];
        REG_INTR_BUDGET:  cfg.intr_budget  <= cfg_data[CNT_W-1:0];
        REG_SHORTEST_LEN: cfg.shortest_len <= cfg_data[MINLEN_W-1:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  // Advance the held item once the queue can absorb a full burst
  assign advance       = in_valid && room;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Hold payload while the item waits
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sym_q  <= s_axis_tdata[SYM_W-1:0];
      last_q <= s_axis_tlast;
    end
  end

  irs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .item_go     (advance),
    .symbol      (sym_q),
    .last_symbol (last_q),
    .cfg         (cfg),
    .burst       (burst)
  );

  irs_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .burst     (burst),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {out_res.segment_end, out_res.segment_begin};
  assign m_axis_tlast = out_res.end_of_burst;

endmodule

`default_nettype wire

### sv/irs_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module irs_chk import irs_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [2*POS_W-1:0]   m_axis_tdata,
  input logic                 m_axis_tlast
);

  // Output valid holds until taken
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  // Stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result pending after reset");

  // Input backpressure only comes from pending results
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind interrupted_run_segmenter irs_chk u_irs_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
